>>> sv/lzsd_pkg.sv
// Shared constants and types for the LZSS stream decoder.
`default_nettype none

package lzsd_pkg;

	// Byte and pair field widths.
	localparam int BYTE_W = 8;
	localparam int POS_W  = 12;
	localparam int LEN_W  = 5;

	// Match length coding: a pair copies (code + MATCH_BIAS + 1) bytes.
	localparam int MAX_MATCH  = 18;
	localparam int MATCH_BIAS = 2;

	// Access request from the sequencer to the history ring.
	typedef struct packed {
		logic              we;
		logic [BYTE_W-1:0] wdata;
		logic              re;
	} hreq_t;

endpackage

`default_nettype wire

>>> sv/lzsd_history.sv
// History ring: byte memory, write pointer, fill count and read bypass.
`default_nettype none

module lzsd_history #(
	parameter int WINDOW_SIZE = 4096,
	localparam int AW = $clog2(WINDOW_SIZE)
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire lzsd_pkg::hreq_t            req,
	input  wire logic [AW-1:0]              raddr,
	output logic [lzsd_pkg::BYTE_W-1:0]     rdata
);
	import lzsd_pkg::*;

	logic [BYTE_W-1:0] mem [WINDOW_SIZE];
	logic [BYTE_W-1:0] rd_q;
	logic [BYTE_W-1:0] bypd_q;
	logic              byp_q;
	logic              ok_q;
	logic [AW-1:0]     wpos_q;
	logic [AW:0]       fill_q;
	logic [AW:0]       ofs_raw;
	logic [AW:0]       ofs;
	logic              hit_wr;

	// Writes run from the reset pointer in order, so an entry has been written
	// exactly when its distance from the reset pointer is below the fill count.
	always_comb begin
		ofs_raw = {1'b0, raddr} + (AW+1)'(MAX_MATCH);
		if (ofs_raw >= (AW+1)'(WINDOW_SIZE)) begin
			ofs = ofs_raw - (AW+1)'(WINDOW_SIZE);
		end else begin
			ofs = ofs_raw;
		end
	end

	// A read that hits the entry written in the same cycle takes the new byte.
	assign hit_wr = req.we && (raddr == wpos_q);

	// Storage array with a registered read port.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[wpos_q] <= req.wdata;
		end
		if (req.re) begin
			rd_q   <= mem[raddr];
			bypd_q <= req.wdata;
		end
	end

	// Pointer, fill count and read qualifiers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q <= AW'(WINDOW_SIZE - MAX_MATCH);
			fill_q <= '0;
			byp_q  <= 1'b0;
			ok_q   <= 1'b0;
		end else begin
			if (req.we) begin
				if (wpos_q == AW'(WINDOW_SIZE - 1)) begin
					wpos_q <= '0;
				end else begin
					wpos_q <= wpos_q + 1'b1;
				end
				if (fill_q != (AW+1)'(WINDOW_SIZE)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (req.re) begin
				byp_q <= hit_wr;
				ok_q  <= hit_wr || (ofs < fill_q);
			end
		end
	end

	// Entries never written read as zero.
	always_comb begin
		if (!ok_q) begin
			rdata = '0;
		end else if (byp_q) begin
			rdata = bypd_q;
		end else begin
			rdata = rd_q;
		end
	end

endmodule

`default_nettype wire

>>> sv/lzss_stream_decoder.sv
// LZSS stream decoder top level: byte parser and copy sequencer.
//
//   channel | direction | fields                | handshake
//   in      | input     | in_byte               | in_valid / in_ready
//   out     | output    | out_byte, last_of_run | out_valid / out_ready
//
// Flag, literal and first pair bytes are taken in the idle state. A second
// pair byte starts a copy: the position is brought into the window by
// repeatedly subtracting WINDOW_SIZE when the window is below 4096 bytes, then
// the history ring copies one byte per cycle while the output is not stalled.
// Reset is asynchronous; the ring reads as zero until written, tracked by a
// fill count, so no clearing pass is needed. The block takes no input beat
// while a copy runs, and a stalled output beat stalls the copy.
`default_nettype none

module lzss_stream_decoder #(
	parameter int WINDOW_SIZE = 4096
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [lzsd_pkg::BYTE_W-1:0] in_byte,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [lzsd_pkg::BYTE_W-1:0]     out_byte,
	output logic                            last_of_run
);
	import lzsd_pkg::*;

	localparam int AW = $clog2(WINDOW_SIZE);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_REDUCE = 3'b010,
		ST_COPY   = 3'b100
	} st_t;

	typedef enum logic [3:0] {
		PH_FLAG = 4'b0001,
		PH_LIT  = 4'b0010,
		PH_PLO  = 4'b0100,
		PH_PHI  = 4'b1000
	} ph_t;

	st_t               st_q;
	ph_t               ph_q;
	ph_t               ph_adv;
	logic [15:0]       flag_q;
	logic [15:0]       flag_nx;
	logic [BYTE_W-1:0] plo_q;
	logic [POS_W-1:0]  addr_q;
	logic [LEN_W-1:0]  rd_left_q;
	logic [LEN_W-1:0]  wr_left_q;
	logic              pend_s1;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              last_q;
	logic              slot_free;
	logic              acc;
	logic              eng;
	hreq_t             hreq;
	logic [BYTE_W-1:0] hist_rdata;

	lzsd_history #(
		.WINDOW_SIZE(WINDOW_SIZE)
	) u_hist (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (hreq),
		.raddr (addr_q[AW-1:0]),
		.rdata (hist_rdata)
	);

	// Handshake and engine enables.
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (st_q == ST_IDLE) && slot_free;
	assign acc       = in_valid && in_ready;
	assign eng       = (st_q == ST_COPY) && slot_free;

	// Next unit after a literal or a finished pair.
	always_comb begin
		flag_nx = {1'b0, flag_q[15:1]};
		if (!flag_nx[8]) begin
			ph_adv = PH_FLAG;
		end else if (flag_nx[0]) begin
			ph_adv = PH_LIT;
		end else begin
			ph_adv = PH_PLO;
		end
	end

	// Ring accesses: literals are stored on accept, copies as each byte lands.
	always_comb begin
		hreq.we    = (acc && (ph_q == PH_LIT)) || (eng && pend_s1);
		hreq.wdata = (st_q == ST_COPY) ? hist_rdata : in_byte;
		hreq.re    = eng && (rd_left_q != '0);
	end

	// Parser and copy sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			ph_q      <= PH_FLAG;
			flag_q    <= '0;
			plo_q     <= '0;
			addr_q    <= '0;
			rd_left_q <= '0;
			wr_left_q <= '0;
			pend_s1   <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (acc) begin
						case (ph_q)
							PH_FLAG: begin
								flag_q <= {8'hff, in_byte};
								ph_q   <= in_byte[0] ? PH_LIT : PH_PLO;
							end
							PH_LIT: begin
								flag_q <= flag_nx;
								ph_q   <= ph_adv;
							end
							PH_PLO: begin
								plo_q <= in_byte;
								ph_q  <= PH_PHI;
							end
							PH_PHI: begin
								addr_q    <= {in_byte[7:4], plo_q};
								rd_left_q <= LEN_W'(in_byte[3:0]) + LEN_W'(MATCH_BIAS + 1);
								wr_left_q <= LEN_W'(in_byte[3:0]) + LEN_W'(MATCH_BIAS + 1);
								st_q      <= ST_REDUCE;
							end
							default: begin
								ph_q <= PH_FLAG;
							end
						endcase
					end
				end
				ST_REDUCE: begin
					// Bring the position into the window by repeated subtraction.
					if ({1'b0, addr_q} >= (POS_W+1)'(WINDOW_SIZE)) begin
						addr_q <= POS_W'({1'b0, addr_q} - (POS_W+1)'(WINDOW_SIZE));
					end else begin
						pend_s1 <= 1'b0;
						st_q    <= ST_COPY;
					end
				end
				ST_COPY: begin
					if (eng) begin
						// Issue the next read ahead of its write.
						if (rd_left_q != '0) begin
							rd_left_q <= rd_left_q - 1'b1;
							pend_s1   <= 1'b1;
							if (addr_q == POS_W'(WINDOW_SIZE - 1)) begin
								addr_q <= '0;
							end else begin
								addr_q <= addr_q + 1'b1;
							end
						end else begin
							pend_s1 <= 1'b0;
						end
						// Store and emit the byte from the previous read.
						if (pend_s1) begin
							wr_left_q <= wr_left_q - 1'b1;
							if (wr_left_q == LEN_W'(1)) begin
								st_q   <= ST_IDLE;
								flag_q <= flag_nx;
								ph_q   <= ph_adv;
							end
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (hreq.we) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hreq.we) begin
			out_byte_q <= hreq.wdata;
			last_q     <= (st_q == ST_COPY) ? (wr_left_q == LEN_W'(1)) : 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;

endmodule

`default_nettype wire

>>> sv/lzsd_checker.sv
// Port-level checker for the LZSS stream decoder, bound to the top level.
`default_nettype none

module lzsd_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic [lzsd_pkg::BYTE_W-1:0] in_byte,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [lzsd_pkg::BYTE_W-1:0] out_byte,
	input wire logic                        last_of_run
);

	// A waiting input beat holds its payload until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_byte))
		else $error("input beat changed while waiting");

	// A stalled output beat holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_of_run))
		else $error("output beat changed while stalled");

	// No input is taken while a copy still has bytes to deliver.
	a_busy_copy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_run |-> !in_ready)
		else $error("input ready in the middle of a copy");

	// Input is taken only when the output slot can absorb a beat.
	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!out_valid || out_ready))
		else $error("input ready while output slot is full");

	// A copy delivers its bytes back to back when the sink keeps up.
	a_copy_stream: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid)
		else $error("gap inside a copy run");

endmodule

bind lzss_stream_decoder lzsd_checker u_lzsd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.in_byte    (in_byte),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.out_byte   (out_byte),
	.last_of_run(last_of_run)
);

`default_nettype wire
